// ===== design/servo_pwm_ascii_command_core_macros.svh =====
// Assertion macros for the servo PWM ASCII command core.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef SERVO_PWM_ASCII_COMMAND_CORE_MACROS_SVH
`define SERVO_PWM_ASCII_COMMAND_CORE_MACROS_SVH

// check a property outside reset
`define SPAC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at every edge, reset included
`define SPAC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/spac_pkg.sv =====
// Shared constants, types and command/status structs of the servo PWM command core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package spac_pkg;

   localparam int LINE_BUFFER = 8;
   localparam int STORE_DEPTH = LINE_BUFFER - 1;
   localparam int LEN_W       = $clog2(LINE_BUFFER);
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int CFG_W = 16;
   localparam int MAG_W = 10;

   localparam logic [CFG_W-1:0] PERIOD_TOP_RESET    = 16'd39999;
   localparam logic [CFG_W-1:0] PULSE_BASE_RESET    = 16'd2000;
   localparam logic [CFG_W-1:0] PULSE_SPAN_RESET    = 16'd2000;
   localparam logic [CFG_W-1:0] PULSE_COMPARE_RESET = 16'd3000;

   // ceil(2^32 / 180): exact quotient for every angle * span product
   localparam int          RECIP_SHIFT = 32;
   localparam logic [24:0] ANGLE_RECIP = 25'd23860930;
   localparam logic [MAG_W-1:0] ANGLE_MAX     = 10'd180;
   localparam logic [MAG_W-1:0] MAG_LIMIT     = 10'd999;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] CSR_PERIOD_TOP = 2'd0;
   localparam logic [1:0] CSR_PULSE_BASE = 2'd1;
   localparam logic [1:0] CSR_PULSE_SPAN = 2'd2;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam int RSP_DATA_W = 32;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_ECHO_RX,
      OUT_STORE,
      OUT_CR,
      OUT_LF
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        tick;
      logic        store_byte;
      logic        parse_clear;
      logic        parse_step;
      logic        mult;
      logic        div_step;
      logic        update;
      logic        idx_clear;
      logic        idx_inc;
      logic        load_out;
      out_sel_type out_sel;
      logic        out_last;
      logic        clear_len;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic is_eol;
      logic line_empty;
      logic line_full;
      logic idx_at_end;
      logic parse_error;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== design/spac_datapath.sv =====
// Datapath of the servo PWM command core: registers, PWM counter, line store,
// parser, multiplier, reciprocal divide by 180 and output beat register. Uses spac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spac_datapath
   import spac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CFG_W-1:0]      csr_wdata,
   input  wire logic                  req_tuser,
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   input  wire cmd_type               cmd,
   output status_type                 status
);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_DIGIT,
      PH_STOP
   } phase_type;

   logic [CFG_W-1:0] period_top_ff, pulse_base_ff, pulse_span_ff;
   logic [CFG_W-1:0] count_ff, count_in;
   logic             pin_ff, pin_in;
   logic [CFG_W-1:0] compare_ff;
   logic [LEN_W-1:0] len_ff, idx_ff;
   logic [7:0]       store_ff [STORE_DEPTH];
   logic             op_ff;
   logic [7:0]       rx_ff;

   phase_type        phase_ff, phase_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic             err_ff;

   logic [23:0]      prod_ff;
   logic [15:0]      quot_ff;

   logic             rsp_valid_ff;
   logic             out_pin_ff, out_txv_ff, out_err_ff, out_last_ff;
   logic [7:0]       out_byte_ff;
   logic [CFG_W-1:0] out_pulse_ff;

   logic [7:0]       cur_byte;
   logic             is_space, is_digit, is_sign;
   logic [13:0]      acc;
   logic [23:0]      product;
   logic [48:0]      scaled;
   logic [16:0]      sum;
   logic [7:0]       sel_byte;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_top_ff <= PERIOD_TOP_RESET;
         pulse_base_ff <= PULSE_BASE_RESET;
         pulse_span_ff <= PULSE_SPAN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PERIOD_TOP: period_top_ff <= csr_wdata;
            CSR_PULSE_BASE: pulse_base_ff <= csr_wdata;
            CSR_PULSE_SPAN: pulse_span_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pwm tick
   always_comb begin
      count_in = count_ff;
      pin_in   = pin_ff;
      if (count_ff >= period_top_ff) begin
         count_in = '0;
         pin_in   = 1'b1;
      end else begin
         count_in = count_ff + 1'b1;
      end
      if (count_in == compare_ff) pin_in = 1'b0;
   end

   // parser step
   assign cur_byte = store_ff[idx_ff[IDX_W-1:0]];
   assign is_space = (cur_byte == CHAR_SPACE) || (cur_byte == CHAR_TAB) ||
                     (cur_byte == CHAR_VT) || (cur_byte == CHAR_FF);
   assign is_digit = (cur_byte >= CHAR_ZERO) && (cur_byte <= CHAR_NINE);
   assign is_sign  = (cur_byte == CHAR_PLUS) || (cur_byte == CHAR_MINUS);
   assign acc = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} + {10'd0, cur_byte[3:0]};

   always_comb begin
      phase_in = phase_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      case (phase_ff)
         PH_SPACE: begin
            if (is_space) begin
               phase_in = PH_SPACE;
            end else if (is_sign) begin
               neg_in   = (cur_byte == CHAR_MINUS);
               phase_in = PH_DIGIT;
            end else if (is_digit) begin
               mag_in   = {6'd0, cur_byte[3:0]};
               phase_in = PH_DIGIT;
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_DIGIT: begin
            if (is_digit) begin
               mag_in = (acc > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc[MAG_W-1:0];
            end else begin
               phase_in = PH_STOP;
            end
         end
         default: ;
      endcase
   end

   // angle times span, then divide by 180 through the reciprocal
   assign product = mag_ff[7:0] * pulse_span_ff;
   assign scaled  = prod_ff * ANGLE_RECIP;

   assign sum = {1'b0, pulse_base_ff} + {1'b0, quot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pin_ff     <= 1'b0;
         compare_ff <= PULSE_COMPARE_RESET;
         len_ff     <= '0;
      end else begin
         if (cmd.tick) begin
            count_ff <= count_in;
            pin_ff   <= pin_in;
         end
         if (cmd.update) compare_ff <= sum[16] ? '1 : sum[15:0];
         if (cmd.store_byte) len_ff <= len_ff + 1'b1;
         else if (cmd.clear_len) len_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_tuser;
         rx_ff <= req_tdata;
      end
      if (cmd.store_byte) store_ff[len_ff[IDX_W-1:0]] <= rx_ff;
      if (cmd.idx_clear) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
      if (cmd.parse_clear) begin
         phase_ff <= PH_SPACE;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
      end else if (cmd.parse_step) begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
      end
      if (cmd.mult) begin
         err_ff  <= status.parse_error;
         prod_ff <= product;
      end
      if (cmd.div_step) quot_ff <= scaled[RECIP_SHIFT +: CFG_W];
   end

   // output beat
   always_comb begin
      case (cmd.out_sel)
         OUT_ECHO_RX: sel_byte = rx_ff;
         OUT_STORE:   sel_byte = cur_byte;
         OUT_CR:      sel_byte = CHAR_CR;
         OUT_LF:      sel_byte = CHAR_LF;
         default:     sel_byte = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_pin_ff   <= pin_ff;
         out_txv_ff   <= (cmd.out_sel != OUT_NONE);
         out_byte_ff  <= sel_byte;
         out_err_ff   <= err_ff && ((cmd.out_sel == OUT_STORE) || (cmd.out_sel == OUT_CR) ||
                                    (cmd.out_sel == OUT_LF));
         out_pulse_ff <= compare_ff;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_pulse_ff, out_err_ff, out_byte_ff, out_pin_ff};
   assign rsp_tuser  = out_txv_ff;
   assign rsp_tlast  = out_last_ff;

   assign status.op          = op_ff;
   assign status.is_eol      = (rx_ff == CHAR_CR) || (rx_ff == CHAR_LF);
   assign status.line_empty  = (len_ff == '0);
   assign status.line_full   = (len_ff == LEN_W'(STORE_DEPTH));
   assign status.idx_at_end  = (idx_ff == len_ff - 1'b1);
   assign status.parse_error = (neg_ff && (mag_ff != '0)) || (mag_ff > ANGLE_MAX);
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

// ===== design/spac_ctrl.sv =====
// Controller state machine of the servo PWM command core.
// Sequences decode, parse, multiply, divide, update and echo; uses spac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spac_ctrl
   import spac_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_DECODE    = 11'b000_0000_0010,
      ST_EMIT_NONE = 11'b000_0000_0100,
      ST_EMIT_ECHO = 11'b000_0000_1000,
      ST_PARSE     = 11'b000_0001_0000,
      ST_MULT      = 11'b000_0010_0000,
      ST_DIV       = 11'b000_0100_0000,
      ST_UPDATE    = 11'b000_1000_0000,
      ST_ECHO      = 11'b001_0000_0000,
      ST_ECHO_CR   = 11'b010_0000_0000,
      ST_ECHO_LF   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = OUT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.op == OP_TICK) begin
               cmd.tick = 1'b1;
               state_in = ST_EMIT_NONE;
            end else if (status.is_eol) begin
               if (status.line_empty) begin
                  state_in = ST_EMIT_NONE;
               end else begin
                  cmd.parse_clear = 1'b1;
                  cmd.idx_clear   = 1'b1;
                  state_in        = ST_PARSE;
               end
            end else if (status.line_full) begin
               state_in = ST_EMIT_NONE;
            end else begin
               cmd.store_byte = 1'b1;
               state_in       = ST_EMIT_ECHO;
            end
         end
         ST_EMIT_NONE: begin
            cmd.out_sel  = OUT_NONE;
            cmd.out_last = 1'b1;
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_ECHO: begin
            cmd.out_sel  = OUT_ECHO_RX;
            cmd.out_last = 1'b1;
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PARSE: begin
            cmd.parse_step = 1'b1;
            cmd.idx_inc    = 1'b1;
            if (status.idx_at_end) state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult      = 1'b1;
            cmd.idx_clear = 1'b1;
            state_in      = status.parse_error ? ST_ECHO : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_ECHO;
         end
         ST_ECHO: begin
            cmd.out_sel = OUT_STORE;
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.idx_inc  = 1'b1;
               if (status.idx_at_end) state_in = ST_ECHO_CR;
            end
         end
         ST_ECHO_CR: begin
            cmd.out_sel = OUT_CR;
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_ECHO_LF;
            end
         end
         ST_ECHO_LF: begin
            cmd.out_sel  = OUT_LF;
            cmd.out_last = 1'b1;
            if (status.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.clear_len = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ===== design/servo_pwm_ascii_command_core.sv =====
// Servo PWM ASCII command core: one beat in is a timer tick (tuser high) or a
// received serial byte; each beat returns one or more result beats on the rsp side.
// A tick or a plain byte passes through the decode state and is loaded into the output
// register in an emit state; the next beat is accepted only after that load. A CR or LF
// that ends a stored line of L bytes is decoded, parsed byte by byte, multiplied,
// divided by 180 through a reciprocal multiply and used to update the compare value,
// then L + 2 echo beats follow; a line out of range skips the divide and update. A
// stall on rsp_tready holds back each output load. Configuration writes are taken in any
// cycle but belong in idle time.
`timescale 1ns / 1ps
`default_nettype none

`include "servo_pwm_ascii_command_core_macros.svh"

module servo_pwm_ascii_command_core
   import spac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CFG_W-1:0]      csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // rx_byte[7:0]
   input  wire logic                  req_tuser,  // op
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // pin_level, tx_byte, range_error, pulse_ticks
   output logic                       rsp_tuser,  // tx_valid
   output logic                       rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   spac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spac_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   `SPAC_ASSERT(a_busy_after_accept, req_tvalid && req_tready |=> !req_tready, "accepted while busy")
   `SPAC_ASSERT(a_silent_beat_clean, rsp_tvalid && !rsp_tuser |-> rsp_tdata[9:1] == 9'd0 && rsp_tlast, "non-echo beat carries data")
   `SPAC_ASSERT(a_load_needs_slot, cmd.load_out |-> status.out_free, "output beat overwritten")
   `SPAC_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

`default_nettype wire

// ===== verif/servo_pwm_ascii_command_checker.sv =====
// Checker for the servo PWM ASCII command core: predicts the rsp beats caused by each
// accepted req beat and compares them field by field. Depends on spac_pkg.
`timescale 1ns / 1ps

module servo_pwm_ascii_command_checker
   import spac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    mismatch_count,
   output int                    beats_outstanding,
   output int                    beats_checked
);

   typedef struct packed {
      logic        pin;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        range_err;
      logic [15:0] ticks;
      logic        last;
   } servo_beat_type;

   logic [CFG_W-1:0] period_top_q;
   logic [CFG_W-1:0] pulse_base_q;
   logic [CFG_W-1:0] pulse_span_q;
   logic [15:0]      period_count_q;
   logic [15:0]      compare_q;
   logic             pin_q;
   logic [7:0]       line_q [STORE_DEPTH];
   int               line_len;
   servo_beat_type   servo_beats [$];

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
   endfunction

   // atoi-style parse of the stored line; returns 1 when the angle is in range
   function automatic bit parse_angle(output int unsigned angle);
      int          i;
      int unsigned mag;
      bit          neg;
      i = 0;
      mag = 0;
      neg = 1'b0;
      while (i < line_len && is_blank(line_q[i]))
         i++;
      if (i < line_len && (line_q[i] == CHAR_PLUS || line_q[i] == CHAR_MINUS)) begin
         neg = (line_q[i] == CHAR_MINUS);
         i++;
      end
      while (i < line_len && line_q[i] >= CHAR_ZERO && line_q[i] <= CHAR_NINE) begin
         mag = mag * 10 + (line_q[i] - CHAR_ZERO);
         if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
         i++;
      end
      angle = mag;
      return !(neg && mag != 0) && mag <= ANGLE_MAX;
   endfunction

   task automatic push_beat(input logic txv, input logic [7:0] txb, input logic err,
                            input logic last);
      servo_beats.push_back('{pin_q, txv, txb, err, compare_q, last});
   endtask

   task automatic advance_servo(input logic op, input logic [7:0] rx);
      int unsigned angle;
      int unsigned target;
      bit          ok;
      if (op == OP_TICK) begin
         if (period_count_q >= period_top_q) begin
            period_count_q = '0;
            pin_q = 1'b1;
         end else begin
            period_count_q = period_count_q + 1'b1;
         end
         if (period_count_q == compare_q)
            pin_q = 1'b0;
         push_beat(1'b0, 8'h00, 1'b0, 1'b1);
      end else if (rx == CHAR_CR || rx == CHAR_LF) begin
         if (line_len == 0) begin
            push_beat(1'b0, 8'h00, 1'b0, 1'b1);
         end else begin
            ok = parse_angle(angle);
            if (ok) begin
               target = pulse_base_q + (angle * pulse_span_q) / 180;
               compare_q = (target > 32'hFFFF) ? 16'hFFFF : target[15:0];
            end
            for (int i = 0; i < line_len; i++)
               push_beat(1'b1, line_q[i], !ok, 1'b0);
            push_beat(1'b1, CHAR_CR, !ok, 1'b0);
            push_beat(1'b1, CHAR_LF, !ok, 1'b1);
            line_len = 0;
         end
      end else if (line_len < STORE_DEPTH) begin
         line_q[line_len] = rx;
         line_len++;
         push_beat(1'b1, rx, 1'b0, 1'b1);
      end else begin
         push_beat(1'b0, 8'h00, 1'b0, 1'b1);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      servo_beat_type want;
      if (reset) begin
         period_top_q   = PERIOD_TOP_RESET;
         pulse_base_q   = PULSE_BASE_RESET;
         pulse_span_q   = PULSE_SPAN_RESET;
         period_count_q = '0;
         compare_q      = PULSE_COMPARE_RESET;
         pin_q          = 1'b0;
         line_len       = 0;
         mismatch_count = 0;
         beats_checked  = 0;
         servo_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PERIOD_TOP: period_top_q = csr_wdata;
               CSR_PULSE_BASE: pulse_base_q = csr_wdata;
               CSR_PULSE_SPAN: pulse_span_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            beats_checked++;
            if (servo_beats.size() == 0) begin
               mismatch_count++;
               $display("%0t: no beat expected, actual data %0h user %0b last %0b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = servo_beats.pop_front();
               check_field("pin_level", want.pin, rsp_tdata[0]);
               check_field("tx_byte", want.tx_byte, rsp_tdata[8:1]);
               check_field("range_error", want.range_err, rsp_tdata[9]);
               check_field("pulse_ticks", want.ticks, rsp_tdata[25:10]);
               check_field("pad", 0, rsp_tdata[RSP_DATA_W-1:26]);
               check_field("tx_valid", want.tx_valid, rsp_tuser);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            advance_servo(req_tuser, req_tdata);
      end
      beats_outstanding = servo_beats.size();
   end

endmodule

// ===== verif/servo_pwm_ascii_command_core_test.sv =====
// Testbench top for the servo PWM ASCII command core: drives ticks, command lines and
// register settings with random idling; the checker module does prediction and compare.
// Depends on spac_pkg, servo_pwm_ascii_command_core and servo_pwm_ascii_command_checker.
`timescale 1ns / 1ps

module servo_pwm_ascii_command_core_test;
   import spac_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 6;
   localparam int PHASE_BEATS = 22;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [CFG_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;  // rx_byte[7:0]
   logic                  req_tuser;  // op
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // pin_level, tx_byte, range_error, pulse_ticks
   logic                  rsp_tuser;  // tx_valid
   logic                  rsp_tlast;

   int mismatch_count;
   int beats_outstanding;
   int beats_checked;
   int beats_sent;
   int settings_used;
   int quiet_cycles;
   bit idle_on;

   logic [CFG_W-1:0] phase_top  [PHASES] = '{16'd0, 16'd1, 16'd65535, 16'd9, 16'd25,
                                             PERIOD_TOP_RESET};
   logic [CFG_W-1:0] phase_base [PHASES] = '{16'd0, 16'd0, 16'd65535, 16'd2, 16'd0,
                                             PULSE_BASE_RESET};
   logic [CFG_W-1:0] phase_span [PHASES] = '{16'd0, 16'd65535, 16'd65535, 16'd7, 16'd24,
                                             PULSE_SPAN_RESET};

   servo_pwm_ascii_command_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   servo_pwm_ascii_command_checker servo_check (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .mismatch_count    (mismatch_count),
      .beats_outstanding (beats_outstanding),
      .beats_checked     (beats_checked)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stall before each beat while idling is on
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_beat(input logic op, input logic [7:0] data);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_beat(OP_BYTE, s[i]);
   endtask

   task automatic send_bytes(input logic [7:0] line [$]);
      foreach (line[i])
         send_beat(OP_BYTE, line[i]);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(OP_TICK, 8'($urandom));
   endtask

   // hold off until every predicted beat has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (beats_outstanding == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] base,
                             input logic [CFG_W-1:0] span);
      write_reg(CSR_PERIOD_TOP, top);
      write_reg(CSR_PULSE_BASE, base);
      write_reg(CSR_PULSE_SPAN, span);
      settings_used++;
   endtask

   // angle command line with random blanks, sign, size and trailer, sometimes without digits
   task automatic make_command(output logic [7:0] line [$]);
      logic [7:0]  digits [$];
      int unsigned value;
      int          pick;
      line.delete();
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 3))
            0:       line.push_back(CHAR_SPACE);
            1:       line.push_back(CHAR_TAB);
            2:       line.push_back(CHAR_VT);
            default: line.push_back(CHAR_FF);
         endcase
      end
      case ($urandom_range(0, 5))
         0:       line.push_back(CHAR_PLUS);
         1:       line.push_back(CHAR_MINUS);
         default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick <= 6)
         value = $urandom_range(0, 180);
      else if (pick == 7)
         value = $urandom_range(181, 999);
      else
         value = $urandom_range(1000, 99999);
      if (pick != 9) begin
         if (value == 0)
            digits.push_front(CHAR_ZERO);
         while (value > 0) begin
            digits.push_front(8'(CHAR_ZERO + value % 10));
            value /= 10;
         end
         if ($urandom_range(0, 4) == 0)
            digits.push_front(CHAR_ZERO);
         foreach (digits[i])
            line.push_back(digits[i]);
      end
      if ($urandom_range(0, 3) == 0)
         line.push_back(8'($urandom_range(0, 255)));
      line.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic random_burst();
      logic [7:0] line [$];
      logic [7:0] noise;
      int         kind;
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         make_command(line);
         send_bytes(line);
      end else if (kind <= 6) begin
         send_ticks($urandom_range(1, 6));
      end else if (kind == 7) begin
         case ($urandom_range(0, 2))
            0:       noise = 8'h00;
            1:       noise = 8'hFF;
            default: noise = 8'($urandom);
         endcase
         send_beat(OP_BYTE, noise);
      end else if (kind == 8) begin
         repeat ($urandom_range(8, 10))
            line.push_back(8'($urandom_range(8'h21, 8'h7E)));
         line.push_back(CHAR_CR);
         send_bytes(line);
      end else begin
         send_beat(OP_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end
   endtask

   initial begin
      int target;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_PERIOD_TOP;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = OP_BYTE;
      idle_on    = 1'b1;
      beats_sent = 0;
      settings_used = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short period, compare above top until the first command
      set_config(16'd3, 16'd1, 16'd2);
      send_ticks(2);
      send_text("\n");
      send_text("180\r");
      send_ticks(2);
      send_text("\t-0\n");
      send_text("-5\r");
      send_text("+12345");
      send_beat(OP_BYTE, 8'h00);
      send_beat(OP_BYTE, 8'hFF);
      send_text("\r");
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         set_config(phase_top[ph], phase_base[ph], phase_span[ph]);
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target)
            random_burst();
         drain();
      end

      repeat (40) @(posedge clock);
      $display("Run drove %0d request beats under %0d register settings, %0d result beats checked",
               beats_sent, settings_used, beats_checked);
      if (mismatch_count == 0 && beats_outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
